// File: src/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg
// Shared types and constants of the double-buffered ROM responder.
// ----------------------------------------------------------------------------
package drp_pkg;

  typedef enum logic [1:0] {
    OpRead  = 2'd0,
    OpWrite = 2'd1,
    OpFlip  = 2'd2,
    OpNop   = 2'd3
  } op_e;

  // magic processor addresses, compared at 16 bits
  localparam logic [15:0] ArmAddr    = 16'h3fff;
  localparam logic [15:0] FrameAddr  = 16'h3ffe;
  localparam logic [15:0] SecondAddr = 16'h3ffd;
  localparam logic [7:0]  KeyPage    = 8'h3f;

  localparam logic [3:0] SwapDelayReset = 4'd3;

  // result queue depth
  localparam int unsigned OutqDepth = 3;

  typedef struct packed {
    op_e         op;
    logic [13:0] bus_address;
    logic [14:0] host_address;
    logic [7:0]  host_data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        key_valid;
    logic [2:0]  key_slot;
    logic [7:0]  key_code;
    logic        frame_mark;
    logic [31:0] frame_count;
    logic [31:0] flip_count;
    logic        display_bank;
    logic        display_half;
  } rsp_t;

  // per-request status from the control block, everything but the rom byte
  typedef struct packed {
    logic        is_read;
    logic        key_valid;
    logic [2:0]  key_slot;
    logic [7:0]  key_code;
    logic        frame_mark;
    logic [31:0] frame_count;
    logic [31:0] flip_count;
    logic        display_bank;
    logic        display_half;
  } stat_t;

endpackage

// File: src/double_buffered_rom_responder.sv
// ----------------------------------------------------------------------------
// double_buffered_rom_responder
// Emulated cartridge ROM with two swapping banks and magic-address side effects.
// ----------------------------------------------------------------------------
// One request is taken per clock while in_ready_o is high; its result is
// offered at the output once it has entered the result queue (the store read
// and the stage valid are registered at the accept edge, then the result is
// written into the result queue). This path is set by the store's single read
// port and its registered read data; bank/half state, key capture and counters
// update in the accept cycle, so back-to-back requests see each other's
// effects. A three-entry result queue keeps requests flowing while the
// consumer stalls. The store has no reset and no clearing pass: a byte must be
// written by the host before the processor reads it.
module double_buffered_rom_responder #(
  parameter int unsigned ADDRESS_BITS = 14,
  parameter int unsigned KEY_SLOTS    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  drp_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output drp_pkg::rsp_t out_rsp_o,
  input  logic          cfg_we_i,
  input  logic [3:0]    cfg_wdata_i
);

  localparam int unsigned StoreAw = ADDRESS_BITS + 2;

  logic               accept;
  logic               wr_en, rd_en;
  logic [StoreAw-1:0] wr_addr, rd_addr;
  logic [7:0]         wr_data, rd_data;
  drp_pkg::stat_t     stat, stat_q;
  logic               stage_valid_q;
  drp_pkg::rsp_t      push_rsp;
  logic [1:0]         q_count;
  logic [2:0]         in_flight;

  // queue plus the store read stage may hold at most three results
  assign in_flight  = 3'(q_count) + 3'(stage_valid_q);
  assign in_ready_o = (in_flight < 3'(drp_pkg::OutqDepth));
  assign accept     = in_valid_i && in_ready_o;

  drp_ctrl #(
    .ADDRESS_BITS(ADDRESS_BITS),
    .KEY_SLOTS   (KEY_SLOTS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_i      (in_req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .stat_o     (stat)
  );

  drp_rom #(
    .AW(StoreAw)
  ) u_rom (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stat_q <= stat;
    end
  end

  always_comb begin
    push_rsp.read_data    = stat_q.is_read ? rd_data : 8'd0;
    push_rsp.key_valid    = stat_q.key_valid;
    push_rsp.key_slot     = stat_q.key_slot;
    push_rsp.key_code     = stat_q.key_code;
    push_rsp.frame_mark   = stat_q.frame_mark;
    push_rsp.frame_count  = stat_q.frame_count;
    push_rsp.flip_count   = stat_q.flip_count;
    push_rsp.display_bank = stat_q.display_bank;
    push_rsp.display_half = stat_q.display_half;
  end

  drp_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (stage_valid_q),
    .push_rsp_i (push_rsp),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .count_o    (q_count)
  );

endmodule

// File: src/drp_rom.sv
// ----------------------------------------------------------------------------
// drp_rom
// Byte store of both banks: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module drp_rom #(
  parameter int unsigned AW = 16
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] store_q [2**AW];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      store_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= store_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/drp_ctrl.sv
// ----------------------------------------------------------------------------
// drp_ctrl
// Bank/half selection, key capture, countdown and counters; drives the store.
// ----------------------------------------------------------------------------
module drp_ctrl #(
  parameter int unsigned ADDRESS_BITS = 14,
  parameter int unsigned KEY_SLOTS    = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  drp_pkg::req_t           req_i,
  input  logic                    cfg_we_i,
  input  logic [3:0]              cfg_wdata_i,
  output logic                    wr_en_o,
  output logic [ADDRESS_BITS+1:0] wr_addr_o,
  output logic [7:0]              wr_data_o,
  output logic                    rd_en_o,
  output logic [ADDRESS_BITS+1:0] rd_addr_o,
  output drp_pkg::stat_t          stat_o
);

  localparam int unsigned HalfW = ADDRESS_BITS;
  localparam int unsigned BankW = ADDRESS_BITS + 1;
  localparam logic [3:0]  KeySlotsLoad = 4'(KEY_SLOTS);

  logic        display_q, display_d;
  logic        half_q, half_d;
  logic        pending_q, pending_d;
  logic [3:0]  keys_left_q, keys_left_d;
  logic [3:0]  countdown_q, countdown_d;
  logic [31:0] frames_q, frames_d;
  logic [31:0] flips_q, flips_d;
  logic [3:0]  swap_delay_q;

  logic [HalfW-1:0] addr;
  logic [BankW-1:0] haddr;
  logic [15:0]      addr16;
  logic [3:0]       keys_dec;
  logic             key_valid, frame_mark;

  assign addr     = HalfW'(req_i.bus_address);
  assign haddr    = BankW'(req_i.host_address);
  assign addr16   = 16'(addr);
  assign keys_dec = keys_left_q - 4'd1;

  always_comb begin
    display_d   = display_q;
    half_d      = half_q;
    pending_d   = pending_q;
    keys_left_d = keys_left_q;
    countdown_d = countdown_q;
    frames_d    = frames_q;
    flips_d     = flips_q;
    key_valid   = 1'b0;
    frame_mark  = 1'b0;
    if (accept_i) begin
      unique case (req_i.op)
        drp_pkg::OpRead: begin
          if (addr16 == drp_pkg::ArmAddr && keys_left_q == 4'd0) begin
            keys_left_d = KeySlotsLoad;
          end else if (keys_left_q != 4'd0) begin
            // while capturing, only the key page counts; magic codes are key bytes
            if (addr16[15:8] == drp_pkg::KeyPage) begin
              keys_left_d = keys_dec;
              key_valid   = 1'b1;
            end
          end else if (addr16 == drp_pkg::FrameAddr) begin
            half_d = 1'b0;
            if (pending_q) begin
              display_d = ~display_q;
              flips_d   = flips_q + 32'd1;
            end
            frames_d   = frames_q + 32'd1;
            pending_d  = 1'b0;
            frame_mark = 1'b1;
          end else if (addr16 == drp_pkg::SecondAddr) begin
            countdown_d = swap_delay_q;
          end else if (countdown_q != 4'd0) begin
            countdown_d = countdown_q - 4'd1;
            if (countdown_q == 4'd1) begin
              half_d = 1'b1;
            end
          end
        end
        drp_pkg::OpFlip:  pending_d = 1'b1;
        drp_pkg::OpWrite: ;
        drp_pkg::OpNop:   ;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_q    <= 1'b0;
      half_q       <= 1'b0;
      pending_q    <= 1'b0;
      keys_left_q  <= 4'd0;
      countdown_q  <= 4'd0;
      frames_q     <= 32'd0;
      flips_q      <= 32'd0;
      swap_delay_q <= drp_pkg::SwapDelayReset;
    end else begin
      display_q   <= display_d;
      half_q      <= half_d;
      pending_q   <= pending_d;
      keys_left_q <= keys_left_d;
      countdown_q <= countdown_d;
      frames_q    <= frames_d;
      flips_q     <= flips_d;
      if (cfg_we_i) begin
        swap_delay_q <= cfg_wdata_i;
      end
    end
  end

  // byte comes from the current half before any side effect
  assign rd_en_o   = accept_i && (req_i.op == drp_pkg::OpRead);
  assign rd_addr_o = {display_q, half_q, addr};
  // host always writes the back bank
  assign wr_en_o   = accept_i && (req_i.op == drp_pkg::OpWrite);
  assign wr_addr_o = {~display_q, haddr};
  assign wr_data_o = req_i.host_data;

  always_comb begin
    stat_o              = '0;
    stat_o.is_read      = rd_en_o;
    stat_o.key_valid    = key_valid;
    stat_o.key_slot     = key_valid ? keys_dec[2:0] : 3'd0;
    stat_o.key_code     = key_valid ? addr16[7:0] : 8'd0;
    stat_o.frame_mark   = frame_mark;
    stat_o.frame_count  = frames_d;
    stat_o.flip_count   = flips_d;
    stat_o.display_bank = display_d;
    stat_o.display_half = half_d;
  end

endmodule

// File: src/drp_outq.sv
// ----------------------------------------------------------------------------
// drp_outq
// Small result queue decoupling the output handshake from the pipeline.
// ----------------------------------------------------------------------------
module drp_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  drp_pkg::rsp_t push_rsp_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output drp_pkg::rsp_t out_rsp_o,
  output logic [1:0]    count_o
);

  localparam logic [1:0] LastPtr = 2'(drp_pkg::OutqDepth - 1);

  drp_pkg::rsp_t entry_q [drp_pkg::OutqDepth];
  logic [1:0]    wr_ptr_q, wr_ptr_d;
  logic [1:0]    rd_ptr_q, rd_ptr_d;
  logic [1:0]    count_q, count_d;
  logic          pop;

  assign pop = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? 2'd0 : wr_ptr_q + 2'd1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? 2'd0 : rd_ptr_q + 2'd1;
    end
    case ({push_i, pop})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_rsp_i;
    end
  end

  assign out_valid_o = (count_q != 2'd0);
  assign out_rsp_o   = entry_q[rd_ptr_q];
  assign count_o     = count_q;

endmodule

// File: src/drp_checker.sv
// ----------------------------------------------------------------------------
// drp_checker
// Port-level checks of the ROM responder, bound to the top level.
// ----------------------------------------------------------------------------
module drp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input drp_pkg::req_t in_req_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input drp_pkg::rsp_t out_rsp_o
);

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_req_i))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // key fields are zero unless a key byte was captured
  a_key_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.key_valid |->
      out_rsp_o.key_slot == 3'd0 && out_rsp_o.key_code == 8'd0)
    else $error("key fields set without capture");

  // a captured key byte is never also a frame start
  a_key_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.key_valid |-> !out_rsp_o.frame_mark)
    else $error("key capture and frame start together");

  // frame start always selects the first half
  a_frame_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.frame_mark |-> !out_rsp_o.display_half)
    else $error("frame start left second half selected");

endmodule

bind double_buffered_rom_responder drp_checker u_drp_checker (.*);
